// ===== hdl/pbss_pkg.sv =====
// ----------------------------------------------------------------------------
// pbss_pkg: shared types and constants for the prefix bucketed sorted search
// Field widths, request codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package pbss_pkg;

    localparam int KEY_W      = 64;
    localparam int MODE_W     = 2;
    localparam int SHIFT_W    = 6;
    localparam int POS_W      = 12;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PFX,
        ST_LOOK,
        ST_SRCH,
        ST_CMP,
        ST_FIN,
        ST_DONE
    } state_t;

    // found sits in the lowest bit
    typedef struct packed {
        logic             rejected;
        logic [POS_W-1:0] position;
        logic             found;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

// ===== hdl/pbss_ram.sv =====
// ----------------------------------------------------------------------------
// pbss_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pbss_cmp.sv =====
// ----------------------------------------------------------------------------
// pbss_cmp: shared key comparator
// Unsigned magnitude and equality compare of a stored key against the request key.
// ----------------------------------------------------------------------------
module pbss_cmp (
    input  logic [pbss_pkg::KEY_W-1:0] a,
    input  logic [pbss_pkg::KEY_W-1:0] b,
    output logic                       lt,
    output logic                       eq
);

    import pbss_pkg::*;

    assign lt = (a < b);
    assign eq = (a == b);

endmodule

// ===== hdl/pbss_seq.sv =====
// ----------------------------------------------------------------------------
// pbss_seq: search sequencer
// Holds key store and run table, runs loads, binary search queries and clears.
// ----------------------------------------------------------------------------
module pbss_seq #(
    parameter int LIST_DEPTH  = 4096,
    parameter int PREFIX_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pbss_pkg::MODE_W-1:0]  in_mode,
    input  logic [pbss_pkg::KEY_W-1:0]   in_key,
    input  logic [pbss_pkg::SHIFT_W-1:0] shift,
    output logic                         done_valid,
    input  logic                         done_ready,
    output pbss_pkg::result_t            res
);

    import pbss_pkg::*;

    localparam int AW      = $clog2(LIST_DEPTH);
    localparam int CW      = $clog2(LIST_DEPTH + 1);
    localparam int RT_W    = 1 + AW + CW;
    localparam int RT_D    = 2 ** PREFIX_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW:0]   DEPTH_X = (CW+1)'(LIST_DEPTH);

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [PREFIX_BITS-1:0] last_reg, last_next;
    logic [PREFIX_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                   clr_item_reg, clr_item_next;

    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [PREFIX_BITS-1:0] pfx_reg, pfx_next;
    logic                   wide_reg, wide_next;
    logic [CW-1:0]          lo_reg, lo_next;
    logic [CW-1:0]          hi_reg, hi_next;
    logic [CW-1:0]          end_reg, end_next;
    logic [CW-1:0]          mid_reg, mid_next;
    result_t                res_reg, res_next;

    logic [KEY_W-1:0]       shifted;
    logic                   ks_we;
    logic [AW-1:0]          ks_waddr, ks_raddr;
    logic [KEY_W-1:0]       ks_rdata;
    logic                   rt_we;
    logic [PREFIX_BITS-1:0] rt_waddr;
    logic [RT_W-1:0]        rt_wdata, rt_rdata;
    logic                   rt_valid;
    logic [AW-1:0]          rt_start;
    logic [CW-1:0]          rt_len;
    logic [CW:0]            run_end;
    logic                   extend;
    logic [CW-1:0]          mid_w;
    logic                   key_lt, key_eq;

    pbss_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_key_ram (
        .aclk  (aclk),
        .we    (ks_we),
        .waddr (ks_waddr),
        .wdata (key_reg),
        .raddr (ks_raddr),
        .rdata (ks_rdata)
    );

    pbss_ram #(.WIDTH(RT_W), .DEPTH(RT_D)) u_run_ram (
        .aclk  (aclk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (shifted[PREFIX_BITS-1:0]),
        .rdata (rt_rdata)
    );

    pbss_cmp u_cmp (
        .a  (ks_rdata),
        .b  (key_reg),
        .lt (key_lt),
        .eq (key_eq)
    );

    assign shifted  = key_reg >> shift;
    assign rt_valid = rt_rdata[0];
    assign rt_start = rt_rdata[AW:1];
    assign rt_len   = rt_rdata[AW+CW:AW+1];
    assign run_end  = (CW+1)'(rt_start) + (CW+1)'(rt_len);
    assign extend   = (count_reg != '0) && (pfx_reg == last_reg) && rt_valid &&
                      (run_end == (CW+1)'(count_reg));
    assign mid_w    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ks_waddr = count_reg[AW-1:0];
    assign ks_raddr = (lo_reg < hi_reg) ? mid_w[AW-1:0] : lo_reg[AW-1:0];

    assign in_ready   = (state_reg == ST_IDLE);
    assign done_valid = (state_reg == ST_DONE);
    assign res        = res_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_item_next = clr_item_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        pfx_next      = pfx_reg;
        wide_next     = wide_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        end_next      = end_reg;
        mid_next      = mid_reg;
        res_next      = res_reg;
        ks_we         = 1'b0;
        rt_we         = 1'b0;
        rt_waddr      = pfx_reg;
        rt_wdata      = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                rt_we        = 1'b1;
                rt_waddr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = clr_item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    mode_next  = in_mode;
                    key_next   = in_key;
                    state_next = ST_PFX;
                end
            end
            ST_PFX: begin
                pfx_next   = shifted[PREFIX_BITS-1:0];
                wide_next  = |(shifted >> PREFIX_BITS);
                res_next   = '0;
                state_next = ST_DONE;
                case (mode_reg)
                    MODE_LOAD: begin
                        if (count_reg >= DEPTH_C) begin
                            res_next.rejected = 1'b1;
                        end else begin
                            state_next = ST_LOOK;
                        end
                    end
                    MODE_QUERY: begin
                        if (!(|(shifted >> PREFIX_BITS))) begin
                            state_next = ST_LOOK;
                        end
                    end
                    MODE_CLEAR: begin
                        count_next    = '0;
                        last_next     = '0;
                        clr_cnt_next  = '0;
                        clr_item_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_LOOK: begin
                if (mode_reg == MODE_LOAD) begin
                    ks_we = 1'b1;
                    if (!wide_reg) begin
                        rt_we     = 1'b1;
                        last_next = pfx_reg;
                        if (extend) begin
                            rt_wdata = {rt_len + 1'b1, rt_start, 1'b1};
                        end else begin
                            rt_wdata = {CW'(1), count_reg[AW-1:0], 1'b1};
                        end
                    end
                    count_next        = count_reg + 1'b1;
                    res_next.position = POS_W'(count_reg);
                    state_next        = ST_DONE;
                end else if (rt_valid) begin
                    lo_next    = CW'(rt_start);
                    hi_next    = (run_end > DEPTH_X) ? DEPTH_C : run_end[CW-1:0];
                    end_next   = (run_end > DEPTH_X) ? DEPTH_C : run_end[CW-1:0];
                    state_next = ST_SRCH;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SRCH: begin
                mid_next = mid_w;
                if (lo_reg < hi_reg) begin
                    state_next = ST_CMP;
                end else if (lo_reg < end_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP: begin
                if (key_lt) begin
                    lo_next = mid_reg + 1'b1;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRCH;
            end
            ST_FIN: begin
                if (key_eq) begin
                    res_next.found    = 1'b1;
                    res_next.position = POS_W'(lo_reg);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (done_ready) begin
                    clr_item_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            count_reg    <= '0;
            last_reg     <= '0;
            clr_cnt_reg  <= '0;
            clr_item_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_item_reg <= clr_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        key_reg  <= key_next;
        pfx_reg  <= pfx_next;
        wide_reg <= wide_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        end_reg  <= end_next;
        mid_reg  <= mid_next;
        res_reg  <= res_next;
    end

`ifndef SYNTHESIS
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRCH) |-> (lo_reg <= hi_reg) && (hi_reg <= end_reg))
        else $error("search bounds out of order");

    a_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |=> ((hi_reg - lo_reg) < $past(hi_reg - lo_reg)))
        else $error("search interval did not shrink");

    a_clear_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && clr_item_reg) |-> (count_reg == '0))
        else $error("entry count not cleared during clear pass");

    a_res_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        done_valid |-> !(res_reg.found && res_reg.rejected))
        else $error("result both found and rejected");

    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK && mode_reg == MODE_LOAD) |-> (count_reg < DEPTH_C))
        else $error("load written beyond capacity");
`endif

endmodule

// ===== hdl/prefix_bucketed_sorted_search.sv =====
// ----------------------------------------------------------------------------
// prefix_bucketed_sorted_search: prefix indexed binary search over a key list
// Load, query and clear requests against a sorted key list and a run table.
// ----------------------------------------------------------------------------
// Load: prefix, then key store and run table write, then result. Query: prefix,
// run table lookup, then a search and a compare state per step of the binary
// search through the key store read port, then a final equality check. Clear:
// every run table entry is written, one per cycle. One request at a time; a new
// request is taken while a result waits. Reset is synchronous, active low, then
// a clear pass empties the run table before the first request is taken.
module prefix_bucketed_sorted_search #(
    parameter int LIST_DEPTH  = 4096,
    parameter int PREFIX_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pbss_pkg::SHIFT_W-1:0]     cfg_data,   // postfix_shift
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pbss_pkg::KEY_W-1:0]       s_tdata,    // key_value
    input  logic [pbss_pkg::MODE_W-1:0]      s_tuser,    // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pbss_pkg::M_TDATA_W-1:0]   m_tdata     // found, position, rejected
);

    import pbss_pkg::*;

    logic [SHIFT_W-1:0] shift_reg;
    logic               m_valid_reg, m_valid_next;
    result_t            m_res_reg;
    logic               done_valid, done_ready;
    result_t            res;

    pbss_seq #(
        .LIST_DEPTH  (LIST_DEPTH),
        .PREFIX_BITS (PREFIX_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_key     (s_tdata),
        .shift      (shift_reg),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .res        (res)
    );

    assign cfg_ready  = 1'b1;
    assign done_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (done_valid && done_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                shift_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_valid && done_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_res_reg);

endmodule

// ===== bench/prefix_bucketed_sorted_search_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prefix_bucketed_sorted_search_test: self-checking bench for the key search
// A queue-fed driver sends load, query, clear and unused requests. A local
// predictor of the key list and run table works out each result, and a
// monitor compares every returned result field by field. Both sides idle at
// random, and one long result-side stall backs the block up. The shift is
// rewritten between phases.
// ----------------------------------------------------------------------------
module prefix_bucketed_sorted_search_test;
    import pbss_pkg::*;

    localparam int                LIST_DEPTH  = 4096;
    localparam int                PFX_BITS    = 12;
    localparam int                PFX_ENTRIES = 1 << PFX_BITS;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                CYCLE_LIMIT = 2_000_000;
    localparam int                LONG_HOLD   = 800;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } request_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [SHIFT_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic [KEY_W-1:0]     s_tdata   = '0;
    logic [MODE_W-1:0]    s_tuser   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_ready;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;

    request_t         request_queue[$];
    result_t          awaited_outcomes[$];
    logic [KEY_W-1:0] list_keys[$];
    request_t         offered;
    result_t          mon_got;
    result_t          mon_want;

    logic [KEY_W-1:0] key_mem[LIST_DEPTH];
    bit               run_ok[PFX_ENTRIES];
    int unsigned      run_base[PFX_ENTRIES];
    int unsigned      run_len[PFX_ENTRIES];
    int unsigned      entry_total = 0;
    int unsigned      prev_pfx    = 0;
    logic [SHIFT_W-1:0] cur_shift = '0;

    bit quiet_tail     = 1'b0;
    bit long_hold_done = 1'b0;
    int send_gap       = 0;
    int hold_left      = 0;
    int drained        = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int n_loads = 0, n_rejects = 0, n_queries = 0, n_hits = 0;
    int n_clears = 0, n_unused = 0, shift_writes = 0;

    prefix_bucketed_sorted_search #(
        .LIST_DEPTH (LIST_DEPTH),
        .PREFIX_BITS(PFX_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) cycle_count++;

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] low_mask(input int bits);
        return (bits >= KEY_W) ? {KEY_W{1'b1}} : ((64'd1 << bits) - 64'd1);
    endfunction

    function automatic result_t lookup_outcome(input logic [MODE_W-1:0] mode,
                                               input logic [KEY_W-1:0] key);
        result_t          r;
        logic [KEY_W-1:0] pfx_wide;
        bit               fits;
        int unsigned      pfx, idx, lo, hi, mid;
        r        = '0;
        pfx_wide = key >> cur_shift;
        fits     = (pfx_wide >> PFX_BITS) == 0;
        pfx      = int'(pfx_wide[PFX_BITS-1:0]);
        if (mode == MODE_LOAD) begin
            n_loads++;
            if (entry_total >= LIST_DEPTH) begin
                r.rejected = 1'b1;
                n_rejects++;
            end else begin
                idx          = entry_total;
                key_mem[idx] = key;
                if (fits) begin
                    if (idx > 0 && pfx == prev_pfx && run_ok[pfx] &&
                        run_base[pfx] + run_len[pfx] == idx) begin
                        run_len[pfx]++;
                    end else begin
                        run_ok[pfx]   = 1'b1;
                        run_base[pfx] = idx;
                        run_len[pfx]  = 1;
                    end
                    prev_pfx = pfx;
                end
                entry_total = idx + 1;
                r.position  = POS_W'(idx);
            end
        end else if (mode == MODE_QUERY) begin
            n_queries++;
            if (fits && run_ok[pfx]) begin
                lo = run_base[pfx];
                hi = lo + run_len[pfx];
                if (hi > LIST_DEPTH) hi = LIST_DEPTH;
                while (lo < hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (key_mem[mid] < key) lo = mid + 1;
                    else hi = mid;
                end
                if (lo < run_base[pfx] + run_len[pfx] && lo < LIST_DEPTH &&
                    key_mem[lo] == key) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(lo);
                    n_hits++;
                end
            end
        end else if (mode == MODE_CLEAR) begin
            n_clears++;
            foreach (run_ok[i]) run_ok[i] = 1'b0;
            entry_total = 0;
            prev_pfx    = 0;
        end else begin
            n_unused++;
        end
        return r;
    endfunction

    // drive requests; predict each one as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_outcomes.insert(awaited_outcomes.size(),
                                        lookup_outcome(offered.mode, offered.key));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    offered = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered.key;
                    s_tuser  <= offered.mode;
                    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 9);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side ready: short random stalls, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) drained++;
            if (!long_hold_done && drained >= 100 && m_tvalid && m_tready &&
                request_queue.size() >= 4) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = m_tdata[RES_W-1:0];
            if (awaited_outcomes.size() == 0) begin
                error_count++;
                $error("result with nothing awaited: m_tdata %h", m_tdata);
            end else begin
                mon_want = awaited_outcomes.pop_front();
                if (mon_got.found !== mon_want.found) begin
                    error_count++;
                    $error("found: expected %0d, got %0d", mon_want.found, mon_got.found);
                end
                if (mon_got.position !== mon_want.position) begin
                    error_count++;
                    $error("position: expected %0d, got %0d",
                           mon_want.position, mon_got.position);
                end
                if (mon_got.rejected !== mon_want.rejected) begin
                    error_count++;
                    $error("rejected: expected %0d, got %0d",
                           mon_want.rejected, mon_got.rejected);
                end
            end
        end
    end

    task automatic queue_req(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key);
        request_queue.insert(request_queue.size(), request_t'{mode: mode, key: key});
        if (mode == MODE_LOAD) list_keys.insert(list_keys.size(), key);
        else if (mode == MODE_CLEAR) list_keys.delete();
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (request_queue.size() != 0 || s_tvalid || awaited_outcomes.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_shift = value;
        shift_writes++;
    endtask

    function automatic logic [KEY_W-1:0] pick_query_key(input int span_bits);
        logic [KEY_W-1:0] k;
        int               sel;
        sel = $urandom_range(0, 19);
        if (list_keys.size() != 0 && sel < 15) begin
            k = list_keys[$urandom_range(0, list_keys.size() - 1)];
            if (sel == 13) k = k + 64'd1;
            if (sel == 14) k = k - 64'd1;
        end else if (sel < 18) begin
            k = rand64() & low_mask(span_bits);
        end else begin
            k = rand64();
        end
        return k;
    endfunction

    // a clear or four queries first, then ascending loads with random content, a little noise, then queries
    task automatic key_phase(input bit start_clear);
        logic [KEY_W-1:0] k, span, step_cap;
        int               span_bits, n_load, n_query;
        span_bits = ($urandom_range(0, 2) == 0) ? int'(cur_shift) + 2
                                                 : int'(cur_shift) + PFX_BITS;
        span      = low_mask(span_bits);
        n_load    = $urandom_range(4, 40);
        n_query   = $urandom_range(10, 40);
        step_cap  = (span >> 1) / n_load;
        k         = rand64() & (span >> 1);
        if (start_clear) queue_req(MODE_CLEAR, rand64());
        else repeat (4) queue_req(MODE_QUERY, pick_query_key(span_bits));
        repeat (n_load) begin
            k = k + rand64() % (step_cap + 64'd1);
            queue_req(MODE_LOAD, k);
            if ($urandom_range(0, 15) == 0) queue_req(MODE_LOAD, rand64());
            if ($urandom_range(0, 24) == 0) queue_req(MODE_UNUSED, rand64());
        end
        repeat (n_query) queue_req(MODE_QUERY, pick_query_key(span_bits));
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [SHIFT_W-1:0] shift_pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // shift 0: every key below 4096 is its own prefix
        queue_req(MODE_QUERY, 64'd0);
        queue_req(MODE_UNUSED, {KEY_W{1'b1}});
        queue_req(MODE_LOAD, 64'd0);
        queue_req(MODE_LOAD, 64'd1);
        queue_req(MODE_LOAD, 64'd1);
        queue_req(MODE_LOAD, 64'd5);
        queue_req(MODE_LOAD, 64'd4095);
        queue_req(MODE_LOAD, 64'd4096);
        queue_req(MODE_LOAD, {KEY_W{1'b1}});
        queue_req(MODE_LOAD, 64'd5);
        queue_req(MODE_QUERY, 64'd1);
        queue_req(MODE_QUERY, 64'd5);
        queue_req(MODE_QUERY, 64'd4095);
        queue_req(MODE_QUERY, 64'd4096);
        queue_req(MODE_QUERY, {KEY_W{1'b1}});
        queue_req(MODE_QUERY, 64'd3);
        queue_req(MODE_QUERY, 64'd0);
        queue_req(MODE_CLEAR, {KEY_W{1'b1}});
        queue_req(MODE_QUERY, 64'd0);

        // unsorted run under one prefix, then a shift change over live runs
        write_shift(6'd4);
        queue_req(MODE_LOAD, 64'h35);
        queue_req(MODE_LOAD, 64'h31);
        queue_req(MODE_LOAD, 64'h3F);
        queue_req(MODE_QUERY, 64'h31);
        queue_req(MODE_QUERY, 64'h3F);
        queue_req(MODE_QUERY, 64'h35);
        write_shift(6'd8);
        queue_req(MODE_QUERY, 64'h35);
        queue_req(MODE_QUERY, 64'h31);

        for (int p = 0; p < 18; p++) begin
            if (p == 15) quiet_tail = 1'b1;
            case (p)
                0: shift_pick = 6'd63;
                1: shift_pick = 6'd0;
                2: shift_pick = 6'd11;
                default: shift_pick = SHIFT_W'($urandom_range(0, 63));
            endcase
            write_shift(shift_pick);
            key_phase(p % 4 != 3);
        end

        wait_idle();
        repeat (64) @(posedge aclk);
        if (awaited_outcomes.size() != 0) begin
            error_count++;
            $error("%0d results never arrived", awaited_outcomes.size());
        end
        $display("Covered %0d loads (%0d refused on a full list), %0d queries (%0d hits),",
                 n_loads, n_rejects, n_queries, n_hits);
        $display("%0d clears, %0d unused-mode requests, %0d shift writes from 0 to 63",
                 n_clears, n_unused, shift_writes);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
